@@ hw/rtl/rtg4m_pkg.sv @@
// shared types and constants for the rgb to gray converter
// depends on nothing; used by the front end, the root cells and the top level
`timescale 1ns / 1ps

package rtg4m_pkg;

  typedef enum logic [1:0] {
    MODE_SQRT601 = 2'd0,
    MODE_SUM709  = 2'd1,
    MODE_SUM601  = 2'd2,
    MODE_RMS     = 2'd3
  } brightness_mode_e;

  // q0.16 weights, each triple sums to 65536
  localparam logic [15:0] W601_R = 16'd19595;
  localparam logic [15:0] W601_G = 16'd38470;
  localparam logic [15:0] W601_B = 16'd7471;
  localparam logic [15:0] W709_R = 16'd13933;
  localparam logic [15:0] W709_G = 16'd46871;
  localparam logic [15:0] W709_B = 16'd4732;

  localparam int unsigned GrayW  = 8;
  localparam int unsigned RadW   = 18;
  localparam int unsigned NCells = GrayW;

  // one beat handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             root;   // run the bit search
    logic             x3;     // compare 3*n*n instead of n*n
    logic [RadW-1:0]  v;      // radicand
    logic [GrayW-1:0] n;      // partial result
    logic [GrayW-1:0] mask;   // bit under trial
  } rtg4m_beat_t;

endpackage

@@ hw/rtl/rtg4m_front.sv @@
// front end: squares, weighted products and sums, then the first beat of the root chain
// depends on rtg4m_pkg
`timescale 1ns / 1ps

module rtg4m_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [1:0]             mode_i,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  output rtg4m_pkg::rtg4m_beat_t beat_o
);

  // stage 1
  logic        s1_vld_q;
  logic [1:0]  s1_mode_q;
  logic [15:0] sq_r_q, sq_g_q, sq_b_q;
  logic [23:0] wp_r_q, wp_g_q, wp_b_q;
  logic [15:0] w_r, w_g, w_b;

  // stage 2
  logic        s2_vld_q;
  logic [1:0]  s2_mode_q;
  logic [31:0] ws_r_q, ws_g_q, ws_b_q;
  logic [23:0] sum_w_q;
  logic [17:0] t_q;

  // stage 3
  rtg4m_pkg::rtg4m_beat_t beat_d, beat_q;
  logic [31:0] s_sum;

  always_comb begin
    if (mode_i == rtg4m_pkg::MODE_SUM709) begin
      w_r = rtg4m_pkg::W709_R;
      w_g = rtg4m_pkg::W709_G;
      w_b = rtg4m_pkg::W709_B;
    end else begin
      w_r = rtg4m_pkg::W601_R;
      w_g = rtg4m_pkg::W601_G;
      w_b = rtg4m_pkg::W601_B;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_i;
    sq_r_q    <= {8'd0, red_i} * {8'd0, red_i};
    sq_g_q    <= {8'd0, green_i} * {8'd0, green_i};
    sq_b_q    <= {8'd0, blue_i} * {8'd0, blue_i};
    wp_r_q    <= {8'd0, w_r} * {16'd0, red_i};
    wp_g_q    <= {8'd0, w_g} * {16'd0, green_i};
    wp_b_q    <= {8'd0, w_b} * {16'd0, blue_i};

    s2_mode_q <= s1_mode_q;
    ws_r_q    <= {16'd0, rtg4m_pkg::W601_R} * {16'd0, sq_r_q};
    ws_g_q    <= {16'd0, rtg4m_pkg::W601_G} * {16'd0, sq_g_q};
    ws_b_q    <= {16'd0, rtg4m_pkg::W601_B} * {16'd0, sq_b_q};
    sum_w_q   <= wp_r_q + wp_g_q + wp_b_q;
    t_q       <= {2'd0, sq_r_q} + {2'd0, sq_g_q} + {2'd0, sq_b_q};
  end

  always_comb begin
    s_sum       = ws_r_q + ws_g_q + ws_b_q;
    beat_d.vld  = s2_vld_q;
    beat_d.mask = 8'h80;
    unique case (s2_mode_q)
      rtg4m_pkg::MODE_SQRT601: begin
        // floor(sqrt(s)) >> 8 equals the integer root of s >> 16
        beat_d.root = 1'b1;
        beat_d.x3   = 1'b0;
        beat_d.v    = {2'd0, s_sum[31:16]};
        beat_d.n    = '0;
      end
      rtg4m_pkg::MODE_RMS: begin
        beat_d.root = 1'b1;
        beat_d.x3   = 1'b1;
        beat_d.v    = t_q;
        beat_d.n    = '0;
      end
      default: begin
        // weighted sums are done here and just ride the chain
        beat_d.root = 1'b0;
        beat_d.x3   = 1'b0;
        beat_d.v    = t_q;
        beat_d.n    = sum_w_q[23:16];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

@@ hw/rtl/rtg4m_cell.sv @@
// one cell of the root chain: decides one result bit and passes the beat on
// depends on rtg4m_pkg
`timescale 1ns / 1ps

module rtg4m_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtg4m_pkg::rtg4m_beat_t beat_i,
  output rtg4m_pkg::rtg4m_beat_t beat_o
);

  rtg4m_pkg::rtg4m_beat_t beat_d, beat_q;
  logic [7:0]  cand;
  logic [15:0] sq;
  logic [17:0] cmp;

  always_comb begin
    cand = beat_i.n | beat_i.mask;
    sq   = {8'd0, cand} * {8'd0, cand};
    cmp  = {2'd0, sq} + (beat_i.x3 ? {1'b0, sq, 1'b0} : 18'd0);

    beat_d      = beat_i;
    beat_d.mask = beat_i.mask >> 1;
    if (beat_i.root && (cmp <= beat_i.v)) begin
      beat_d.n = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

@@ hw/rtl/rgb_to_gray_four_modes_top.sv @@
// rgb to gray converter, four selectable formulas: front end plus a chain of root cells
// depends on rtg4m_pkg, rtg4m_front and rtg4m_cell
// throughput: one pixel per cycle; busy is never raised, the pipeline of
// three front stages and eight root cells (one result bit each) always moves
// reset clears the mode register to 0 and all valid bits; results cannot be stalled
`timescale 1ns / 1ps

module rgb_to_gray_four_modes_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       brightness_mode_we_i,
  input  logic [1:0] brightness_mode_i,
  output logic       gray_valid_o,
  output logic [7:0] gray_level_o
);

  logic [1:0] mode_q;
  rtg4m_pkg::rtg4m_beat_t chain [rtg4m_pkg::NCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rtg4m_pkg::MODE_SQRT601;
    end else if (brightness_mode_we_i) begin
      mode_q <= brightness_mode_i;
    end
  end

  assign busy = 1'b0;

  rtg4m_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start),
    .mode_i  (mode_q),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .beat_o  (chain[0])
  );

  for (genvar k = 0; k < rtg4m_pkg::NCells; k++) begin : g_cell
    rtg4m_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[k]),
      .beat_o (chain[k+1])
    );
  end

  assign gray_valid_o = chain[rtg4m_pkg::NCells].vld;
  assign gray_level_o = chain[rtg4m_pkg::NCells].n;

endmodule

@@ tb/rgb_to_gray_four_modes_top_tb.sv @@
// self-checking testbench for the four-mode rgb to gray converter
// depends on rtg4m_pkg and rgb_to_gray_four_modes_top; a clocked driver and monitor,
// with a bit-exact gray predictor checked against every result beat
`timescale 1ns / 1ps

module rgb_to_gray_four_modes_top_tb;

  localparam int unsigned Latency    = 11;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseLen   = 150;
  localparam int unsigned NumPhases  = 8;

  // corner pixels run under every mode
  localparam logic [23:0] CornerPixels [6] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h55AA01
  };

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int unsigned gap_pct;  // chance of an idle burst after this beat
  } pixel_beat_t;

  typedef struct {
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;
    rtg4m_pkg::brightness_mode_e mode;
    logic [7:0]                  gray;
  } gray_expect_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] red_i = '0;
  logic [7:0] green_i = '0;
  logic [7:0] blue_i = '0;
  logic       brightness_mode_we_i = 1'b0;
  logic [1:0] brightness_mode_i = '0;
  logic       gray_valid_o;
  logic [7:0] gray_level_o;

  pixel_beat_t                 pixel_q[$];
  gray_expect_t                gray_exp_q[$];
  rtg4m_pkg::brightness_mode_e cur_mode = rtg4m_pkg::MODE_SQRT601;
  logic                        beat_taken = 1'b0;
  int unsigned                 gap_left = 0;
  int unsigned                 pending_cnt = 0;
  int unsigned                 stall_cycles = 0;
  int unsigned                 pixels_sent = 0;
  int unsigned                 grays_checked = 0;
  int unsigned                 mode_writes = 0;
  int unsigned                 mismatches = 0;

  rgb_to_gray_four_modes_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .red_i                (red_i),
    .green_i              (green_i),
    .blue_i               (blue_i),
    .brightness_mode_we_i (brightness_mode_we_i),
    .brightness_mode_i    (brightness_mode_i),
    .gray_valid_o         (gray_valid_o),
    .gray_level_o         (gray_level_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] predict_gray(rtg4m_pkg::brightness_mode_e mode,
                                              logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b);
    logic [63:0] acc;
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    case (mode)
      rtg4m_pkg::MODE_SQRT601: begin
        acc = 64'(rtg4m_pkg::W601_R) * r * r + 64'(rtg4m_pkg::W601_G) * g * g
            + 64'(rtg4m_pkg::W601_B) * b * b;
        // integer sqrt of the q.16 sum, then drop the 8 fractional bits
        for (int k = 15; k >= 0; k--) begin
          trial = root | (64'd1 << k);
          if (trial * trial <= acc) root = trial;
        end
        root = root >> 8;
      end
      rtg4m_pkg::MODE_SUM709: begin
        root = (64'(rtg4m_pkg::W709_R) * r + 64'(rtg4m_pkg::W709_G) * g
              + 64'(rtg4m_pkg::W709_B) * b) >> 16;
      end
      rtg4m_pkg::MODE_SUM601: begin
        root = (64'(rtg4m_pkg::W601_R) * r + 64'(rtg4m_pkg::W601_G) * g
              + 64'(rtg4m_pkg::W601_B) * b) >> 16;
      end
      default: begin
        acc = 64'(r) * r + 64'(g) * g + 64'(b) * b;
        // largest n with 3*n*n <= sum of squares
        for (int k = 7; k >= 0; k--) begin
          trial = root | (64'd1 << k);
          if (64'd3 * trial * trial <= acc) root = trial;
        end
      end
    endcase
    return (root > 64'd255) ? 8'd255 : root[7:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // driver: a beat stays on the bus until it is taken
  always @(negedge clk_i) begin : driver
    pixel_beat_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        start <= 1'b1;
        red_i <= nxt.red;
        green_i <= nxt.green;
        blue_i <= nxt.blue;
        if ($urandom_range(0, 99) < nxt.gap_pct) gap_left <= $urandom_range(1, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on every input beat, check on every result beat
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    gray_expect_t want;
    logic         take;
    if (!rst_ni) begin
      cur_mode <= rtg4m_pkg::MODE_SQRT601;
      beat_taken <= 1'b0;
      pending_cnt <= 0;
      stall_cycles <= 0;
    end else begin
      take = start && !busy;
      beat_taken <= take;
      if (brightness_mode_we_i)
        cur_mode <= rtg4m_pkg::brightness_mode_e'(brightness_mode_i);
      if (gray_valid_o) begin
        if (gray_exp_q.size() == 0) begin
          report_mismatch($sformatf("gray level %0d with no pixel pending", gray_level_o));
        end else begin
          want = gray_exp_q.pop_front();
          grays_checked++;
          if (gray_level_o !== want.gray)
            report_mismatch($sformatf("%s rgb=%0d,%0d,%0d gray want %0d got %0d",
                want.mode.name(), want.red, want.green, want.blue, want.gray,
                gray_level_o));
        end
      end
      if (take) begin
        want.red = red_i;
        want.green = green_i;
        want.blue = blue_i;
        want.mode = cur_mode;
        want.gray = predict_gray(cur_mode, red_i, green_i, blue_i);
        gray_exp_q.insert(gray_exp_q.size(), want);
        pixels_sent++;
      end
      pending_cnt <= gray_exp_q.size();
      stall_cycles <= (take || gray_valid_o) ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: no beat for %0d cycles", StallLimit);
    $display("Verification failed");
    $finish;
  end

  // checked at the rising edge, so it sees values from before that edge
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || start || pending_cnt != 0);
  endtask

  task automatic write_mode(rtg4m_pkg::brightness_mode_e m);
    wait_idle();
    @(negedge clk_i);
    brightness_mode_we_i = 1'b1;
    brightness_mode_i = m;
    @(negedge clk_i);
    brightness_mode_we_i = 1'b0;
    mode_writes++;
    @(posedge clk_i);
  endtask

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             int unsigned gap_pct);
    pixel_beat_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.gap_pct = gap_pct;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic queue_random(int unsigned n, int unsigned gap_pct);
    int base;
    int ch [3];
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        6: foreach (ch[c]) ch[c] = $urandom_range(0, 1) ? 255 : 0;
        7: begin
          // near-gray pixels, where all formulas should roughly agree
          base = $urandom_range(0, 255);
          foreach (ch[c]) begin
            ch[c] = base + int'($urandom_range(0, 6)) - 3;
            if (ch[c] < 0) ch[c] = 0;
            if (ch[c] > 255) ch[c] = 255;
          end
        end
        8: begin
          foreach (ch[c]) ch[c] = 0;
          ch[$urandom_range(0, 2)] = $urandom_range(0, 255);
        end
        9: foreach (ch[c]) ch[c] = $urandom_range(240, 255);
        default: foreach (ch[c]) ch[c] = $urandom_range(0, 255);
      endcase
      queue_pixel(ch[0][7:0], ch[1][7:0], ch[2][7:0], gap_pct);
    end
  endtask

  initial begin : stimulus
    rtg4m_pkg::brightness_mode_e phase_mode;
    int unsigned                 gap_pct;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // corner pixels: reset mode first, then each mode written in turn
    for (int m = 0; m < 4; m++) begin
      if (m != 0) write_mode(rtg4m_pkg::brightness_mode_e'(m));
      foreach (CornerPixels[i])
        queue_pixel(CornerPixels[i][23:16], CornerPixels[i][15:8], CornerPixels[i][7:0],
                    (m == 2) ? 40 : 0);
    end

    // random pixels; first phases sweep every mode, the last one runs without gaps
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: phase_mode = rtg4m_pkg::MODE_SQRT601;
        1: phase_mode = rtg4m_pkg::MODE_RMS;
        2: phase_mode = rtg4m_pkg::MODE_SUM709;
        3: phase_mode = rtg4m_pkg::MODE_SUM601;
        default: phase_mode = rtg4m_pkg::brightness_mode_e'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 30;
        default: gap_pct = 60;
      endcase
      if (ph == NumPhases - 1) gap_pct = 0;
      write_mode(phase_mode);
      queue_random(PhaseLen, gap_pct);
    end

    wait_idle();
    repeat (Latency + 4) @(posedge clk_i);
    $display("%0d pixels sent, %0d gray levels checked over %0d mode writes",
             pixels_sent, grays_checked, mode_writes);
    $display("corner pixels under all four modes, then %0d random phases", NumPhases);
    if (mismatches == 0 && gray_exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (gray_exp_q.size() != 0)
        report_mismatch($sformatf("%0d gray levels never arrived", gray_exp_q.size()));
      $display("Verification failed");
    end
    $finish;
  end

endmodule
